### rtl/ucs_pkg.sv
// Shared types and constants for the UTF-8 control character scrubber.
`timescale 1ns / 1ps

package ucs_pkg;

    // Byte that replaces every control sequence.
    localparam logic [7:0] SPACE_BYTE = 8'h20;

    // Most result bytes that one input byte can release.
    localparam int unsigned GROUP_MAX = 3;

    // One input request.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_item_t;

    // One result request.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_item_t;

    // Result bytes released by one input byte, oldest in entry zero.
    typedef struct packed {
        logic [1:0]                count;
        logic [GROUP_MAX-1:0][7:0] bytes;
        logic                      last;
    } group_t;

endpackage

### rtl/ucs_front.sv
// Front end: takes input bytes, matches control sequences and forms result groups.
`timescale 1ns / 1ps

module ucs_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  ucs_pkg::in_item_t in_data,
    output logic             grp_valid,
    output ucs_pkg::group_t  grp_data
);

    // Undecided lead bytes carried over to the next input byte.
    logic [1:0] held_count_reg;
    logic [1:0] held_count_next;
    logic [7:0] held_bytes_reg [2];
    logic [7:0] held_bytes_next [2];

    // Scan window: held bytes followed by the new byte, padded to four entries.
    logic [7:0] scan_b [4];
    logic [1:0] scan_n;
    logic [1:0] pos;
    logic [1:0] rem;
    logic [1:0] cnt;
    logic       done;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic [ucs_pkg::GROUP_MAX-1:0][7:0] obytes;

    function automatic logic is_ascii_ctl(input logic [7:0] c);
        is_ascii_ctl = (c < 8'h20) || (c == 8'h7f);
    endfunction

    function automatic logic match_two(input logic [7:0] a, input logic [7:0] b);
        match_two = ((a == 8'hc2) && (b >= 8'h80) && (b <= 8'h9f)) ||
                    ((a == 8'hd8) && (b == 8'h9c));
    endfunction

    function automatic logic match_three(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        match_three = (a == 8'he2) &&
                      (((b == 8'h80) && (((c >= 8'h8b) && (c <= 8'h8f)) ||
                                         ((c >= 8'ha8) && (c <= 8'hae)))) ||
                       ((b == 8'h81) && (c >= 8'ha6) && (c <= 8'ha9)));
    endfunction

    // True when the remaining one or two bytes may still grow into a match.
    function automatic logic could_match(input logic [7:0] a, input logic [7:0] b,
                                         input logic [1:0] n);
        if (n == 2'd1)
        begin
            could_match = (a == 8'hc2) || (a == 8'hd8) || (a == 8'he2);
        end
        else if (n == 2'd2)
        begin
            could_match = (a == 8'he2) && ((b == 8'h80) || (b == 8'h81));
        end
        else
        begin
            could_match = 1'b0;
        end
    endfunction

    // Build the scan window from the held prefix and the new byte.
    always_comb
    begin
        scan_b[0] = in_data.in_byte;
        scan_b[1] = 8'h00;
        scan_b[2] = 8'h00;
        scan_b[3] = 8'h00;
        scan_n    = 2'd1;
        case (held_count_reg)
            2'd0:
            begin
                scan_b[0] = in_data.in_byte;
                scan_n    = 2'd1;
            end
            2'd1:
            begin
                scan_b[0] = held_bytes_reg[0];
                scan_b[1] = in_data.in_byte;
                scan_n    = 2'd2;
            end
            default:
            begin
                scan_b[0] = held_bytes_reg[0];
                scan_b[1] = held_bytes_reg[1];
                scan_b[2] = in_data.in_byte;
                scan_n    = 2'd3;
            end
        endcase
    end

    // Walk the window: each step releases one byte or parks the rest as a prefix.
    always_comb
    begin
        pos             = 2'd0;
        cnt             = 2'd0;
        done            = 1'b0;
        rem             = 2'd0;
        c0              = 8'h00;
        c1              = 8'h00;
        c2              = 8'h00;
        obytes          = '0;
        held_count_next = 2'd0;
        held_bytes_next = held_bytes_reg;
        for (int i = 0; i < ucs_pkg::GROUP_MAX; i++)
        begin
            if (!done && (pos < scan_n))
            begin
                rem = scan_n - pos;
                c0  = scan_b[pos];
                c1  = scan_b[pos + 2'd1];
                c2  = scan_b[pos + 2'd2];
                if (is_ascii_ctl(c0))
                begin
                    obytes[cnt] = ucs_pkg::SPACE_BYTE;
                    cnt         = cnt + 2'd1;
                    pos         = pos + 2'd1;
                end
                else if ((rem >= 2'd2) && match_two(c0, c1))
                begin
                    obytes[cnt] = ucs_pkg::SPACE_BYTE;
                    cnt         = cnt + 2'd1;
                    pos         = pos + 2'd2;
                end
                else if ((rem == 2'd3) && match_three(c0, c1, c2))
                begin
                    obytes[cnt] = ucs_pkg::SPACE_BYTE;
                    cnt         = cnt + 2'd1;
                    pos         = pos + 2'd3;
                end
                else if (!in_data.in_last && could_match(c0, c1, rem))
                begin
                    held_bytes_next[0] = c0;
                    held_bytes_next[1] = c1;
                    held_count_next    = rem;
                    done               = 1'b1;
                end
                else
                begin
                    obytes[cnt] = c0;
                    cnt         = cnt + 2'd1;
                    pos         = pos + 2'd1;
                end
            end
        end
    end

    // Group handed to the queue; a fully parked byte releases nothing.
    assign grp_valid      = accept && (cnt != 2'd0);
    assign grp_data.count = cnt;
    assign grp_data.bytes = obytes;
    assign grp_data.last  = in_data.in_last;

    // Prefix count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= 2'd0;
        end
        else if (accept)
        begin
            held_count_reg <= held_count_next;
        end
    end

    // Prefix bytes carry no reset; only the count says which are meaningful.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            held_bytes_reg <= held_bytes_next;
        end
    end

`ifndef SYNTHESIS
    // At most two lead bytes are ever parked.
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg != 2'd3)
        else $error("ucs_front: prefix count out of range");

    // The end of a string leaves nothing parked.
    a_last_flushes: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.in_last) |=> (held_count_reg == 2'd0))
        else $error("ucs_front: prefix kept past end of string");
`endif

endmodule

### rtl/ucs_fifo.sv
// Short queue of result groups between the front end and the back end.
`timescale 1ns / 1ps

module ucs_fifo #(
    parameter int unsigned DEPTH = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  ucs_pkg::group_t wr_data,
    output logic            full,
    output logic            rd_valid,
    input  logic            rd_en,
    output ucs_pkg::group_t rd_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ucs_pkg::group_t   mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              do_wr;
    logic              do_rd;

    assign full     = (count_reg == FULL_CNT);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    // Pointer and occupancy updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    // Occupancy never passes the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("ucs_fifo: occupancy beyond depth");
`endif

endmodule

### rtl/ucs_back.sv
// Back end: unpacks result groups and presents one byte at a time in an output register.
`timescale 1ns / 1ps

module ucs_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               grp_valid,
    input  ucs_pkg::group_t    grp_data,
    output logic               grp_take,
    output logic               empty,
    input  logic               pop,
    output ucs_pkg::out_item_t out_data
);

    // Group being unpacked and the index of its next byte.
    logic              cur_valid_reg;
    logic              cur_valid_next;
    ucs_pkg::group_t   cur_reg;
    logic [1:0]        idx_reg;
    logic [1:0]        idx_next;

    // Output register.
    logic               out_valid_reg;
    logic               out_valid_next;
    ucs_pkg::out_item_t out_reg;

    logic out_free;
    logic emit;
    logic at_end;
    logic cur_done;

    assign empty    = !out_valid_reg;
    assign out_data = out_reg;
    assign out_free = !out_valid_reg || pop;
    assign emit     = cur_valid_reg && out_free;
    assign at_end   = (idx_reg == (cur_reg.count - 2'd1));
    assign cur_done = emit && at_end;
    assign grp_take = grp_valid && (!cur_valid_reg || cur_done);

    // Next state of the unpacking stage and the output register.
    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            idx_next = idx_reg + 2'd1;
        end
        if (grp_take)
        begin
            cur_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
        else if (cur_done)
        begin
            cur_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (grp_take)
        begin
            cur_reg <= grp_data;
        end
        if (emit)
        begin
            out_reg.out_byte <= cur_reg.bytes[idx_reg];
            out_reg.out_last <= cur_reg.last && at_end;
        end
    end

`ifndef SYNTHESIS
    // The byte index stays inside the group being unpacked.
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (idx_reg < cur_reg.count))
        else $error("ucs_back: byte index beyond group");

    // A new group is only taken once the current one has gone out.
    a_take_order: assert property (@(posedge clk) disable iff (!rst_n)
        (grp_take && cur_valid_reg) |-> cur_done)
        else $error("ucs_back: group overwritten before it was sent");
`endif

endmodule

### rtl/utf8_control_char_scrubber_unit.sv
// Top level of the UTF-8 control character scrubber.
`timescale 1ns / 1ps

// Usage:
//   Input queue side: drive in_data and raise push; a request is taken at a
//   rising edge with push high and full low. in_last marks a string's end.
//   Result queue side: while empty is low, out_data holds the oldest result;
//   it is taken at a rising edge with pop high.
//   Each input byte releases zero to three result bytes. Control bytes and
//   the listed control sequences come out as a single space; up to two lead
//   bytes are held back until they can be classified, and a string's end
//   releases whatever is held.
//   Path: a released byte passes from the group queue through the unpacking
//   register into the output register, which drives out_data.
//   Throughput: one input byte per cycle while full is low, bounded by the
//   back end, which sends one result byte per cycle while the result side pops;
//   a group of several bytes occupies it while the group queue absorbs further input.
//   Stalls: when pop stays low the output register holds, the group queue
//   fills and full rises; nothing is dropped.
//   Reset: rst_n clears the held prefix, the group queue and the output
//   register; the block accepts input from the first edge after reset.
module utf8_control_char_scrubber_unit #(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  ucs_pkg::in_item_t  in_data,
    output logic               empty,
    input  logic               pop,
    output ucs_pkg::out_item_t out_data
);

    logic            accept;
    logic            grp_valid;
    ucs_pkg::group_t grp_data;
    logic            q_valid;
    ucs_pkg::group_t q_data;
    logic            q_take;

    assign accept = push && !full;

    // Classification of incoming bytes.
    ucs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_data   (in_data),
        .grp_valid (grp_valid),
        .grp_data  (grp_data)
    );

    // Decoupling queue of result groups.
    ucs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (grp_valid),
        .wr_data  (grp_data),
        .full     (full),
        .rd_valid (q_valid),
        .rd_en    (q_take),
        .rd_data  (q_data)
    );

    // Byte-by-byte delivery.
    ucs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .grp_valid (q_valid),
        .grp_data  (q_data),
        .grp_take  (q_take),
        .empty     (empty),
        .pop       (pop),
        .out_data  (out_data)
    );

endmodule
